### hw/rtl/rgb_led_store_fade_and_spi_bit_encode_top_assert.svh
// Assertion macros for the LED colour store.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RGB_LED_STORE_FADE_AND_SPI_BIT_ENCODE_TOP_ASSERT_SVH
`define RGB_LED_STORE_FADE_AND_SPI_BIT_ENCODE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RGBFX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RGBFX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGBFX_ASSERT_IMP(lbl, ante, cons, msg)
`define RGBFX_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/rgbfx_pkg.sv
`timescale 1ns / 1ps
package rgbfx_pkg;

  // Number of LEDs held in the colour store.
  localparam int LED_COUNT = 256;
  localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_IDX_W = 10;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [LED_IDX_W-1:0] led_idx_t;
  typedef logic [7:0]           byte_t;
  typedef logic [23:0]          colour_t;
  typedef logic [23:0]          code_t;
  typedef logic [2:0]           pat_t;
  typedef logic [0:0]           cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_ONE_BIT  = 1'b0;
  localparam cfg_idx_t CFG_ZERO_BIT = 1'b1;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_STEP    = 2'd1,
    OP_SET_ALL = 2'd2,
    OP_ENCODE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CH_GREEN = 2'd0,
    CH_RED   = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHAN,
    S_WRITE,
    S_FILL,
    S_DONE
  } state_t;

  // Result of the shared channel unit for one colour byte.
  typedef struct packed {
    byte_t next_val;
    logic  differ;
    code_t code;
  } chan_res_t;

endpackage

### hw/rtl/rgb_led_store_fade_and_spi_bit_encode_top.sv
`timescale 1ns / 1ps
// LED colour store with fading and three-bit SPI encoding of each data bit.
// The input channel (in_valid/in_ready) carries one operation per transfer:
// set one LED, step one LED toward a target, set every LED, or encode one LED.
// The output channel (out_valid/out_ready) returns exactly one result per
// operation. A single fade/encode unit handles one colour byte per cycle and
// the colour memory has one write and one registered read port, so an item is
// worked on alone. Set all writes one memory row per cycle. in_ready rises
// in the same cycle as out_valid, when the result is registered. After reset
// the block clears every memory row to zero with in_ready low; configuration
// writes are taken at any time.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and worked on, and holds before its result stage
// until the register is free.
`include "rgb_led_store_fade_and_spi_bit_encode_top_assert.svh"
module rgb_led_store_fade_and_spi_bit_encode_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  rgbfx_pkg::cfg_idx_t  cfg_index,
  input  rgbfx_pkg::pat_t      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgbfx_pkg::op_t       opcode,
  input  rgbfx_pkg::led_idx_t  led_index,
  input  rgbfx_pkg::byte_t     step_size,
  input  rgbfx_pkg::byte_t     red_value,
  input  rgbfx_pkg::byte_t     green_value,
  input  rgbfx_pkg::byte_t     blue_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 changed_flag,
  output logic                 index_error,
  output rgbfx_pkg::code_t     green_code,
  output rgbfx_pkg::code_t     red_code,
  output rgbfx_pkg::code_t     blue_code
);
  import rgbfx_pkg::*;

  localparam logic [LED_IDX_W:0] IDX_LIMIT = (LED_IDX_W + 1)'(LED_COUNT);

  state_t    state;
  state_t    state_next;
  pat_t      one_pat;
  pat_t      zero_pat;
  op_t       item_op;
  addr_t     item_addr;
  logic      item_err;
  byte_t     item_step;
  colour_t   tgt_col;
  colour_t   new_col;
  code_t     code_g;
  code_t     code_r;
  code_t     code_b;
  logic      changed;
  chan_t     ch;
  addr_t     sweep_addr;
  logic      sweep_last;
  logic      accept;
  logic      idx_ok;
  logic      out_free;
  logic      out_load;
  logic      mem_we;
  logic      mem_re;
  addr_t     mem_wr_addr;
  colour_t   mem_wr_data;
  colour_t   mem_rd_data;
  byte_t     cur_byte;
  byte_t     tgt_byte;
  chan_res_t unit_res;

  assign accept     = in_valid && in_ready;
  assign idx_ok     = {1'b0, led_index} < IDX_LIMIT;
  assign out_free   = !out_valid || out_ready;
  assign sweep_last = (sweep_addr == addr_t'(LED_COUNT - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      one_pat  <= pat_t'(6);
      zero_pat <= pat_t'(4);
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_ONE_BIT:  one_pat  <= cfg_data;
        CFG_ZERO_BIT: zero_pat <= cfg_data;
      endcase
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        priority if (!in_valid)             state_next = S_IDLE;
        else if (opcode == OP_SET_ALL)      state_next = S_FILL;
        else if (!idx_ok)                   state_next = S_DONE;
        else if (opcode == OP_SET)          state_next = S_WRITE;
        else                                state_next = S_READ;
      end
      S_READ:  state_next = S_CHAN;
      S_CHAN: begin
        if (ch == CH_BLUE) state_next = (item_op == OP_STEP) ? S_WRITE : S_DONE;
      end
      S_WRITE: state_next = S_DONE;
      S_FILL: begin
        if (sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_CLEAR: mem_we   = 1'b1;
      S_IDLE:  in_ready = 1'b1;
      S_READ:  mem_re   = 1'b1;
      S_CHAN:  ;
      S_WRITE: mem_we   = 1'b1;
      S_FILL:  mem_we   = 1'b1;
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Row counter for the clearing pass and the set-all sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (state == S_CLEAR || state == S_FILL) begin
      sweep_addr <= sweep_last ? '0 : sweep_addr + addr_t'(1);
    end
  end

  // Capture the item; the new colour starts as the item colour for set and set all.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= opcode;
      item_addr <= addr_t'(led_index);
      item_err  <= (opcode != OP_SET_ALL) && !idx_ok;
      item_step <= step_size;
      tgt_col   <= {green_value, red_value, blue_value};
      new_col   <= {green_value, red_value, blue_value};
      code_g    <= '0;
      code_r    <= '0;
      code_b    <= '0;
      changed   <= 1'b0;
    end else if (state == S_CHAN) begin
      unique case (ch)
        CH_GREEN: begin
          new_col[23:16] <= unit_res.next_val;
          if (item_op == OP_ENCODE) code_g <= unit_res.code;
        end
        CH_RED: begin
          new_col[15:8] <= unit_res.next_val;
          if (item_op == OP_ENCODE) code_r <= unit_res.code;
        end
        default: begin
          new_col[7:0] <= unit_res.next_val;
          if (item_op == OP_ENCODE) code_b <= unit_res.code;
        end
      endcase
      if (item_op == OP_STEP && unit_res.differ) changed <= 1'b1;
    end
  end

  // Channel counter of the shared unit.
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      ch <= CH_GREEN;
    end else if (state == S_CHAN) begin
      unique case (ch)
        CH_GREEN: ch <= CH_RED;
        CH_RED:   ch <= CH_BLUE;
        default:  ch <= CH_GREEN;
      endcase
    end
  end

  // Byte selection for the shared unit.
  always_comb begin
    unique case (ch)
      CH_GREEN: begin
        cur_byte = mem_rd_data[23:16];
        tgt_byte = tgt_col[23:16];
      end
      CH_RED: begin
        cur_byte = mem_rd_data[15:8];
        tgt_byte = tgt_col[15:8];
      end
      default: begin
        cur_byte = mem_rd_data[7:0];
        tgt_byte = tgt_col[7:0];
      end
    endcase
  end

  assign mem_wr_addr = (state == S_WRITE) ? item_addr : sweep_addr;
  assign mem_wr_data = (state == S_CLEAR) ? '0 : new_col;

  rgbfx_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .re      (mem_re),
    .rd_addr (item_addr),
    .rd_data (mem_rd_data)
  );

  rgbfx_chan u_chan (
    .cur      (cur_byte),
    .tgt      (tgt_byte),
    .step     (item_step),
    .one_pat  (one_pat),
    .zero_pat (zero_pat),
    .res      (unit_res)
  );

  // Output register; a finished result waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      changed_flag <= changed;
      index_error  <= item_err;
      green_code   <= code_g;
      red_code     <= code_r;
      blue_code    <= code_b;
    end
  end

  `RGBFX_ASSERT_NXT(a_done_loads, state == S_DONE && out_free, out_valid,
                    "result not presented after the result stage")
  `RGBFX_ASSERT_IMP(a_err_clean, out_valid && index_error,
                    !changed_flag && green_code == '0 && red_code == '0 && blue_code == '0,
                    "index error result carries data")
  `RGBFX_ASSERT_IMP(a_no_bad_write, state == S_WRITE, !item_err,
                    "memory write for an out-of-range index")
  `RGBFX_ASSERT_NXT(a_fill_ends, state == S_FILL && sweep_last, state == S_DONE,
                    "set-all sweep did not finish at the last row")

endmodule

### hw/rtl/rgbfx_mem.sv
`timescale 1ns / 1ps
module rgbfx_mem (
  input  logic              clk,
  input  logic              we,
  input  rgbfx_pkg::addr_t   wr_addr,
  input  rgbfx_pkg::colour_t wr_data,
  input  logic              re,
  input  rgbfx_pkg::addr_t   rd_addr,
  output rgbfx_pkg::colour_t rd_data
);
  import rgbfx_pkg::*;

  colour_t mem [LED_COUNT];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/rgbfx_chan.sv
`timescale 1ns / 1ps
module rgbfx_chan (
  input  rgbfx_pkg::byte_t     cur,
  input  rgbfx_pkg::byte_t     tgt,
  input  rgbfx_pkg::byte_t     step,
  input  rgbfx_pkg::pat_t      one_pat,
  input  rgbfx_pkg::pat_t      zero_pat,
  output rgbfx_pkg::chan_res_t res
);
  import rgbfx_pkg::*;

  byte_t delta;
  byte_t move;

  // Fade one channel toward its target without overshoot, and expand the
  // current byte, most significant bit first, into SPI patterns.
  always_comb begin
    delta = (tgt > cur) ? (tgt - cur) : (cur - tgt);
    move = (delta < step) ? delta : step;
    res.differ   = (tgt != cur);
    res.next_val = (tgt > cur) ? (cur + move) : (cur - move);
    for (int k = 0; k < 8; k++) begin
      res.code[23 - 3*k -: 3] = cur[7 - k] ? one_pat : zero_pat;
    end
  end

endmodule
